FILE: rtl/core/rar_pkg.sv
// rational add / reduce: shared types, operation codes and widths
// used by rar_ctrl, rar_dp and rational_add_reduce_unit
package rar_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int S_TDATA_W     = 136;
	localparam int M_TDATA_W     = 72;

	// command field of an input request
	localparam logic [1:0] CMD_REDUCE = 2'd0;
	localparam logic [1:0] CMD_ADD    = 2'd1;
	localparam logic [1:0] CMD_NEG    = 2'd2;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_SETA,
		OP_GINIT,
		OP_EDIV,
		OP_NDIV,
		OP_DDIV,
		OP_SAVEA_SETB,
		OP_SAVEB_GL,
		OP_SETNEG,
		OP_MUL_BDAD,
		OP_LDIV,
		OP_DIV_LBD,
		OP_MUL_BN,
		OP_MUL_BDT,
		OP_DIV_LAD,
		OP_MUL_AN,
		OP_SUM,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t  op;
		logic start;
	} rar_cmd_t;

	typedef struct packed {
		logic ey_zero;
		logic g_trivial;
		logic unit_done;
		logic dz;
		logic ovs;
		logic out_free;
	} rar_stat_t;

endpackage

FILE: rtl/core/rational_add_reduce_unit.sv
// rational add / reduce unit: one request in, one reduced fraction out
// a reduce runs one divide per euclid step on the shared bit-serial unit, then divides both
// parts by the gcd unless it is 0 or 1; a zero denominator goes straight to the output,
// and an add reduces both operands, combines them over the lcm and reduces the sum
// throughput: one item at a time, set by the single 64-bit iterative divide/multiply unit
// reset: arst_n clears the controller and the output valid flag; no clearing pass
module rational_add_reduce_unit #(
	parameter int WORD_BITS = rar_pkg::WORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// cmd[1:0], a_num[33:2], a_den[65:34], b_num[97:66], b_den[129:98], zero fill
	input  logic [rar_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// res_num[31:0], res_den[63:32], den_zero[64], overflow[65], zero fill
	output logic [rar_pkg::M_TDATA_W-1:0]  m_tdata
);

	rar_pkg::rar_cmd_t  cmd;
	rar_pkg::rar_stat_t stat;
	logic signed [31:0] res_num, res_den;
	logic               den_zero, overflow;

	// controller only steps the sequence; all arithmetic lives in the datapath
	rar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_cmd   (s_tdata[1:0]),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath holds the output register, so a finished result can wait
	// while the next request is taken and worked on
	rar_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_cmd    (s_tdata[1:0]),
		.a_num     (s_tdata[33:2]),
		.a_den     (s_tdata[65:34]),
		.b_num     (s_tdata[97:66]),
		.b_den     (s_tdata[129:98]),
		.res_num   (res_num),
		.res_den   (res_den),
		.den_zero  (den_zero),
		.overflow  (overflow),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	assign m_tdata = {6'b0, overflow, den_zero, res_den, res_num};

	// a request is taken only from idle, so the next cycle is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready held after accepting a request");

	// a result appears only from the finish step
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.op == rar_pkg::OP_FINISH))
		else $error("result valid without finish");

	// zero denominator results carry zero fraction and no overflow
	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64] |-> (m_tdata[63:0] == 64'd0) && !m_tdata[65])
		else $error("zero denominator result not cleared");

	// unit is never started while the controller waits on it
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !cmd.start)
		else $error("unit started twice in a row");

endmodule

FILE: rtl/core/rar_iter.sv
// shared iterative unit: signed 64-bit truncating divide or wrapping multiply,
// one bit per cycle; depends on nothing outside this file
module rar_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               is_mul,
	input  logic signed [63:0] opa,
	input  logic signed [63:0] opb,
	output logic               done,
	output logic signed [63:0] quo,
	output logic signed [63:0] rem
);

	logic        busy_q, done_q, mul_q, bz_q, nq_q, nr_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q, quo_q, dvs_q;
	logic [63:0] abs_a, abs_b;
	logic [64:0] sh, diff;

	assign abs_a = opa[63] ? 64'(-opa) : 64'(opa);
	assign abs_b = opb[63] ? 64'(-opb) : 64'(opb);
	assign sh    = {acc_q, quo_q[63]};
	assign diff  = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mul_q <= is_mul;
			acc_q <= '0;
			bz_q  <= (opb == 64'sd0);
			nq_q  <= opa[63] ^ opb[63];
			nr_q  <= opa[63];
			if (is_mul) begin
				quo_q <= 64'(opb);
				dvs_q <= 64'(opa);
			end else begin
				quo_q <= abs_a;
				dvs_q <= abs_b;
			end
		end else if (busy_q) begin
			if (mul_q) begin
				if (quo_q[0])
					acc_q <= acc_q + dvs_q;
				dvs_q <= {dvs_q[62:0], 1'b0};
				quo_q <= {1'b0, quo_q[63:1]};
			end else begin
				// restoring step: subtract when the partial remainder allows
				if (!diff[64]) begin
					acc_q <= diff[63:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					acc_q <= sh[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
		end
	end

	assign done = done_q;

	always_comb begin
		if (mul_q)
			quo = signed'(acc_q);
		else if (bz_q)
			quo = '0;
		else if (nq_q)
			quo = signed'(-quo_q);
		else
			quo = signed'(quo_q);
		if (bz_q)
			rem = '0;
		else if (nr_q)
			rem = signed'(-acc_q);
		else
			rem = signed'(acc_q);
	end

endmodule

FILE: rtl/core/rar_dp.sv
// datapath: operand registers, euclid registers, output register
// depends on rar_pkg and rar_iter
module rar_dp #(
	parameter int WORD_BITS = rar_pkg::WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rar_pkg::rar_cmd_t   cmd,
	output rar_pkg::rar_stat_t  stat,
	input  logic [1:0]          in_cmd,
	input  logic signed [31:0]  a_num,
	input  logic signed [31:0]  a_den,
	input  logic signed [31:0]  b_num,
	input  logic signed [31:0]  b_den,
	output logic signed [31:0]  res_num,
	output logic signed [31:0]  res_den,
	output logic                den_zero,
	output logic                overflow,
	output logic                out_valid,
	input  logic                out_ready
);

	logic signed [63:0] an_q, ad_q, bn_q, bd_q, n_q, d_q, ex_q, ey_q, l_q, t_q, t1_q, t2_q;
	logic               dz_q, ovs_q, out_valid_q;
	logic signed [63:0] ua, ub, uq, ur, sum;
	logic               is_mul, udone, sum_ov, fit_n, fit_d;

	localparam logic signed [63:0] HI = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] LO = -HI - 64'sd1;

	always_comb begin
		ua     = n_q;
		ub     = ex_q;
		is_mul = 1'b0;
		unique case (cmd.op)
			rar_pkg::OP_EDIV:     begin ua = ex_q; ub = ey_q; end
			rar_pkg::OP_NDIV:     begin ua = n_q;  ub = ex_q; end
			rar_pkg::OP_DDIV:     begin ua = d_q;  ub = ex_q; end
			rar_pkg::OP_MUL_BDAD: begin ua = bd_q; ub = ad_q; is_mul = 1'b1; end
			rar_pkg::OP_LDIV:     begin ua = t_q;  ub = ex_q; end
			rar_pkg::OP_DIV_LBD:  begin ua = l_q;  ub = bd_q; end
			rar_pkg::OP_MUL_BN:   begin ua = bn_q; ub = t_q;  is_mul = 1'b1; end
			rar_pkg::OP_MUL_BDT:  begin ua = bd_q; ub = t_q;  is_mul = 1'b1; end
			rar_pkg::OP_DIV_LAD:  begin ua = l_q;  ub = ad_q; end
			rar_pkg::OP_MUL_AN:   begin ua = an_q; ub = t_q;  is_mul = 1'b1; end
			default:              begin ua = n_q;  ub = ex_q; end
		endcase
	end

	rar_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.is_mul (is_mul),
		.opa    (ua),
		.opb    (ub),
		.done   (udone),
		.quo    (uq),
		.rem    (ur)
	);

	assign sum    = t1_q + t2_q;
	assign sum_ov = (t1_q[63] == t2_q[63]) && (sum[63] != t1_q[63]);
	assign fit_n  = (n_q >= LO) && (n_q <= HI);
	assign fit_d  = (d_q >= LO) && (d_q <= HI);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rar_pkg::OP_LOAD: begin
				an_q  <= 64'(a_num);
				ad_q  <= 64'(a_den);
				bn_q  <= 64'(b_num);
				bd_q  <= 64'(b_den);
				dz_q  <= (a_den == 32'sd0) ||
				         (in_cmd == rar_pkg::CMD_ADD && b_den == 32'sd0);
				ovs_q <= 1'b0;
			end
			rar_pkg::OP_SETA: begin
				n_q <= an_q;
				d_q <= ad_q;
			end
			rar_pkg::OP_GINIT: begin
				ex_q <= n_q;
				ey_q <= d_q;
			end
			rar_pkg::OP_SAVEA_SETB: begin
				an_q <= n_q;
				ad_q <= d_q;
				n_q  <= bn_q;
				d_q  <= bd_q;
			end
			rar_pkg::OP_SAVEB_GL: begin
				bn_q <= n_q;
				bd_q <= d_q;
				ex_q <= d_q;
				ey_q <= ad_q;
			end
			rar_pkg::OP_SETNEG: n_q <= -n_q;
			rar_pkg::OP_SUM: begin
				ovs_q <= sum_ov;
				n_q   <= sum;
			end
			rar_pkg::OP_EDIV: if (udone) begin
				ex_q <= ey_q;
				ey_q <= ur;
			end
			rar_pkg::OP_NDIV:     if (udone) n_q  <= uq;
			rar_pkg::OP_DDIV:     if (udone) d_q  <= uq;
			rar_pkg::OP_MUL_BDAD: if (udone) t_q  <= uq;
			rar_pkg::OP_LDIV:     if (udone) l_q  <= uq;
			rar_pkg::OP_DIV_LBD:  if (udone) t_q  <= uq;
			rar_pkg::OP_MUL_BN:   if (udone) t1_q <= uq;
			rar_pkg::OP_MUL_BDT:  if (udone) d_q  <= uq;
			rar_pkg::OP_DIV_LAD:  if (udone) t_q  <= uq;
			rar_pkg::OP_MUL_AN:   if (udone) t2_q <= uq;
			rar_pkg::OP_FINISH: begin
				if (dz_q || ovs_q) begin
					res_num  <= '0;
					res_den  <= '0;
					den_zero <= dz_q;
					overflow <= !dz_q;
				end else begin
					res_num  <= n_q[31:0];
					res_den  <= d_q[31:0];
					den_zero <= 1'b0;
					overflow <= !(fit_n && fit_d);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == rar_pkg::OP_FINISH)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid      = out_valid_q;
	assign stat.ey_zero   = (ey_q == 64'sd0);
	assign stat.g_trivial = (ex_q == 64'sd0) || (ex_q == 64'sd1);
	assign stat.unit_done = udone;
	assign stat.dz        = dz_q;
	assign stat.ovs       = ovs_q;
	assign stat.out_free  = !out_valid_q || out_ready;

endmodule

FILE: rtl/core/rar_ctrl.sv
// controller: sequences reduce, add and negate over the shared unit
// depends on rar_pkg
module rar_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_cmd,
	output logic               in_ready,
	input  rar_pkg::rar_stat_t stat,
	output rar_pkg::rar_cmd_t  cmd
);

	localparam logic [4:0] S_IDLE = 5'd0, S_CHECK = 5'd1, S_GINIT = 5'd2, S_GTEST = 5'd3,
		S_GDONE = 5'd4, S_ISSUE = 5'd5, S_WAIT = 5'd6, S_DDIV = 5'd7, S_REDDONE = 5'd8,
		S_A1 = 5'd9, S_A2 = 5'd10, S_A3 = 5'd11, S_A4 = 5'd12, S_A5 = 5'd13, S_A6 = 5'd14,
		S_SUM = 5'd15, S_SUMCHK = 5'd16, S_OUT = 5'd17;

	localparam logic [2:0] PH_A = 3'd0, PH_B = 3'd1, PH_L = 3'd2, PH_NEG = 3'd3, PH_SUM = 3'd4;

	logic [4:0]      state_q, state_d, ret_q, ret_d;
	logic [2:0]      phase_q, phase_d;
	logic [1:0]      icmd_q, icmd_d;
	rar_pkg::op_t    op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			phase_q <= PH_A;
			icmd_q  <= rar_pkg::CMD_REDUCE;
			op_q    <= rar_pkg::OP_NOP;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			phase_q <= phase_d;
			icmd_q  <= icmd_d;
			op_q    <= op_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		phase_d   = phase_q;
		icmd_d    = icmd_q;
		op_d      = op_q;
		cmd.op    = rar_pkg::OP_NOP;
		cmd.start = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.op  = rar_pkg::OP_LOAD;
				icmd_d  = in_cmd;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.dz) begin
					state_d = S_OUT;
				end else begin
					cmd.op  = rar_pkg::OP_SETA;
					phase_d = PH_A;
					state_d = S_GINIT;
				end
			end
			S_GINIT: begin
				cmd.op  = rar_pkg::OP_GINIT;
				state_d = S_GTEST;
			end
			S_GTEST: begin
				if (stat.ey_zero) begin
					state_d = S_GDONE;
				end else begin
					op_d = rar_pkg::OP_EDIV; ret_d = S_GTEST; state_d = S_ISSUE;
				end
			end
			S_GDONE: begin
				if (phase_q == PH_L) begin
					op_d = rar_pkg::OP_MUL_BDAD; ret_d = S_A1; state_d = S_ISSUE;
				end else if (stat.g_trivial) begin
					state_d = S_REDDONE;
				end else begin
					op_d = rar_pkg::OP_NDIV; ret_d = S_DDIV; state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.op    = op_q;
				cmd.start = 1'b1;
				state_d   = S_WAIT;
			end
			S_WAIT: begin
				cmd.op = op_q;
				if (stat.unit_done)
					state_d = ret_q;
			end
			S_DDIV: begin
				op_d = rar_pkg::OP_DDIV; ret_d = S_REDDONE; state_d = S_ISSUE;
			end
			S_REDDONE: begin
				// the reduced fraction now sits in the working pair
				if (phase_q == PH_A && icmd_q == rar_pkg::CMD_ADD) begin
					cmd.op  = rar_pkg::OP_SAVEA_SETB;
					phase_d = PH_B;
					state_d = S_GINIT;
				end else if (phase_q == PH_A && icmd_q == rar_pkg::CMD_NEG) begin
					cmd.op  = rar_pkg::OP_SETNEG;
					phase_d = PH_NEG;
					state_d = S_GINIT;
				end else if (phase_q == PH_B) begin
					cmd.op  = rar_pkg::OP_SAVEB_GL;
					phase_d = PH_L;
					state_d = S_GTEST;
				end else begin
					state_d = S_OUT;
				end
			end
			S_A1: begin op_d = rar_pkg::OP_LDIV;    ret_d = S_A2;  state_d = S_ISSUE; end
			S_A2: begin op_d = rar_pkg::OP_DIV_LBD; ret_d = S_A3;  state_d = S_ISSUE; end
			S_A3: begin op_d = rar_pkg::OP_MUL_BN;  ret_d = S_A4;  state_d = S_ISSUE; end
			S_A4: begin op_d = rar_pkg::OP_MUL_BDT; ret_d = S_A5;  state_d = S_ISSUE; end
			S_A5: begin op_d = rar_pkg::OP_DIV_LAD; ret_d = S_A6;  state_d = S_ISSUE; end
			S_A6: begin op_d = rar_pkg::OP_MUL_AN;  ret_d = S_SUM; state_d = S_ISSUE; end
			S_SUM: begin
				cmd.op  = rar_pkg::OP_SUM;
				state_d = S_SUMCHK;
			end
			S_SUMCHK: begin
				if (stat.ovs) begin
					state_d = S_OUT;
				end else begin
					phase_d = PH_SUM;
					state_d = S_GINIT;
				end
			end
			S_OUT: if (stat.out_free) begin
				cmd.op  = rar_pkg::OP_FINISH;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
